[hw/rtl/epc_pkg.sv]
// Shared types, constants and microcode program of the entropy pool conditioner.
`default_nettype none
package epc_pkg;

	localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] FIN_MUL_A = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] FIN_MUL_B = 64'h94D049BB133111EB;
	localparam logic [63:0] WORK_SEED = 64'h00000000CAFEBABE;
	localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
	localparam logic [63:0] LCG_INC   = 64'd1442695040888963407;
	localparam int unsigned WORK_ROUNDS = 20;

	localparam int unsigned PC_W = 4;
	localparam logic [PC_W-1:0] PC_HARVEST = 4'd0;
	localparam logic [PC_W-1:0] PC_EXTRACT = 4'd8;

	typedef enum logic [2:0] {
		U_NOP,
		U_ADD,
		U_MLL,
		U_MLH,
		U_MHL,
		U_MIX,
		U_EXT
	} uop_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_LOOP,
		SEQ_END
	} seq_t;

	typedef struct packed {
		uop_t            uop;
		logic            ksel;
		seq_t            seq;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic exec;
		logic load;
		logic second;
		uop_t uop;
		logic ksel;
	} ctrl_t;

	function automatic logic [63:0] make_work();
		logic [63:0] w;
		w = WORK_SEED;
		for (int r = 0; r < WORK_ROUNDS; r++) begin
			w = w * LCG_MUL + LCG_INC;
			w = w ^ (w >> 17);
		end
		return w;
	endfunction

	localparam logic [63:0] WORK = make_work();

	function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t cw;
		cw = '{uop: U_NOP, ksel: 1'b0, seq: SEQ_END, target: PC_HARVEST};
		unique case (pc)
			4'd0: cw = '{uop: U_ADD, ksel: 1'b0, seq: SEQ_NEXT, target: PC_HARVEST};
			4'd1: cw = '{uop: U_MLL, ksel: 1'b0, seq: SEQ_NEXT, target: PC_HARVEST};
			4'd2: cw = '{uop: U_MLH, ksel: 1'b0, seq: SEQ_NEXT, target: PC_HARVEST};
			4'd3: cw = '{uop: U_MHL, ksel: 1'b0, seq: SEQ_NEXT, target: PC_HARVEST};
			4'd4: cw = '{uop: U_MLL, ksel: 1'b1, seq: SEQ_NEXT, target: PC_HARVEST};
			4'd5: cw = '{uop: U_MLH, ksel: 1'b1, seq: SEQ_NEXT, target: PC_HARVEST};
			4'd6: cw = '{uop: U_MHL, ksel: 1'b1, seq: SEQ_NEXT, target: PC_HARVEST};
			4'd7: cw = '{uop: U_MIX, ksel: 1'b0, seq: SEQ_LOOP, target: PC_HARVEST};
			4'd8: cw = '{uop: U_EXT, ksel: 1'b0, seq: SEQ_END, target: PC_HARVEST};
			default: cw = '{uop: U_NOP, ksel: 1'b0, seq: SEQ_END, target: PC_HARVEST};
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/epc_sequencer.sv]
// Microcode sequencer: step counter, feed flag and control word decode.
`default_nettype none
module epc_sequencer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          opcode,
	output logic               in_ready,
	input  wire logic          out_full,
	output epc_pkg::ctrl_t     ctrl
);
	import epc_pkg::*;

	logic            busy_q;
	logic            second_q;
	logic [PC_W-1:0] pc_q;
	ucode_t          cw;
	logic            hold;
	logic            load;

	assign cw       = ucode(pc_q);
	assign in_ready = !busy_q;
	assign load     = in_valid && in_ready;
	assign hold     = (cw.uop == U_EXT) && out_full;

	assign ctrl.exec   = busy_q && !hold;
	assign ctrl.load   = load;
	assign ctrl.second = second_q;
	assign ctrl.uop    = cw.uop;
	assign ctrl.ksel   = cw.ksel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			second_q <= 1'b0;
			pc_q     <= PC_HARVEST;
		end else if (load) begin
			busy_q   <= 1'b1;
			second_q <= 1'b0;
			pc_q     <= opcode ? PC_EXTRACT : PC_HARVEST;
		end else if (busy_q && !hold) begin
			unique case (cw.seq)
				SEQ_NEXT: pc_q <= pc_q + 1'b1;
				SEQ_LOOP: begin
					if (!second_q) begin
						second_q <= 1'b1;
						pc_q     <= cw.target;
					end else begin
						busy_q <= 1'b0;
					end
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> busy_q && !second_q &&
			(pc_q == ($past(opcode) ? PC_EXTRACT : PC_HARVEST)))
		else $error("sequencer did not start at the program entry");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q <= PC_EXTRACT))
		else $error("step counter left the program");

	a_loop_once: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && second_q && !hold && cw.seq == SEQ_LOOP) |=> !busy_q)
		else $error("harvest ran more than two feeds");

endmodule
`default_nettype wire

[hw/rtl/epc_datapath.sv]
// Pool datapath: lanes, feed counter, shared 32x32 multiplier and output register.
`default_nettype none
module epc_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire epc_pkg::ctrl_t ctrl,
	input  wire logic [63:0]    timer_sample,
	output logic [63:0]         random_word,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic                out_full
);
	import epc_pkg::*;

	logic [63:0] lanes_q [4];
	logic [63:0] count_q;
	logic [63:0] gsum_q;
	logic [63:0] samp_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [63:0] word_q;
	logic        out_valid_q;

	logic [63:0] kconst;
	logic [31:0] a_half;
	logic [31:0] k_half;
	logic [63:0] prod;
	logic [63:0] add_in;
	logic [63:0] add_sum;
	logic [63:0] acc_sum;
	logic [63:0] mhl_z;
	logic [1:0]  cur;
	logic [63:0] lane_mix [4];
	logic [63:0] fold;

	assign kconst  = ctrl.ksel ? FIN_MUL_B : FIN_MUL_A;
	assign a_half  = (ctrl.uop == U_MHL) ? z_q[63:32] : z_q[31:0];
	assign k_half  = (ctrl.uop == U_MLH) ? kconst[63:32] : kconst[31:0];
	assign prod    = 64'(a_half) * 64'(k_half);
	assign acc_sum = acc_q + {prod[31:0], 32'd0};
	assign mhl_z   = ctrl.ksel ? (acc_sum ^ (acc_sum >> 31)) : (acc_sum ^ (acc_sum >> 27));

	assign add_in  = ctrl.second ? (samp_q ^ WORK) : samp_q;
	assign add_sum = add_in + gsum_q;

	assign cur = count_q[1:0];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lane_mix[i] = lanes_q[i];
			if (cur == 2'(i)) begin
				lane_mix[i] = lanes_q[i] ^ z_q;
			end
			if (cur == 2'(i + 3)) begin
				lane_mix[i] = lanes_q[i] ^ rotl(lanes_q[(i + 3) % 4] ^ z_q, 17);
			end
		end
	end

	assign fold = lanes_q[0] ^ rotl(lanes_q[1], 13) ^ rotl(lanes_q[2], 29) ^
		rotl(lanes_q[3], 43);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				lanes_q[i] <= '0;
			end
			count_q     <= '0;
			gsum_q      <= GOLDEN;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.exec && ctrl.uop == U_EXT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.exec) begin
				unique case (ctrl.uop)
					U_ADD: begin
						count_q <= count_q + 64'd1;
						gsum_q  <= gsum_q + GOLDEN;
					end
					U_MIX: begin
						for (int i = 0; i < 4; i++) begin
							lanes_q[i] <= lane_mix[i];
						end
					end
					U_EXT: begin
						lanes_q[0] <= lanes_q[0] ^ rotl(fold, 7);
						lanes_q[1] <= lanes_q[1] ^ rotl(fold, 23);
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			samp_q <= timer_sample;
		end
		if (ctrl.exec) begin
			unique case (ctrl.uop)
				U_ADD: z_q    <= add_sum ^ (add_sum >> 30);
				U_MLL: acc_q  <= prod;
				U_MLH: acc_q  <= acc_sum;
				U_MHL: z_q    <= mhl_z;
				U_EXT: word_q <= fold;
				default: begin
				end
			endcase
		end
	end

	assign random_word = word_q;
	assign out_valid   = out_valid_q;
	assign out_full    = out_valid_q && !out_ready;

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.exec && ctrl.uop == U_EXT))
		else $error("output item raised without an extract step");

	a_count_source: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(ctrl.exec && ctrl.uop == U_ADD))
		else $error("feed counter moved outside a feed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(ctrl.exec && ctrl.uop == U_EXT))
		else $error("extract overwrote a waiting item");

endmodule
`default_nettype wire

[hw/rtl/entropy_pool_conditioner_core.sv]
// Top level of the entropy pool conditioner: sequencer plus pool datapath.
//
// A harvest item is taken in when in_ready is high and then occupies the block through both
// of its feeds, so a new item waits until it is done; an extract item runs its extract step
// once the output register is free. The length of a harvest is set by the single 32x32
// multiplier: each 64-bit finalizer product is built from three partial products over
// three microcode steps, two products per feed and two feeds per harvest. The golden
// increment is kept as a running sum, so the counter needs no multiply. A finished word
// waits in the output register while new items are accepted; only an extract stalls on it.
`default_nettype none
module entropy_pool_conditioner_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [63:0] timer_sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      random_word
);
	import epc_pkg::*;

	ctrl_t ctrl;
	logic  out_full;

	epc_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.out_full (out_full),
		.ctrl     (ctrl)
	);

	epc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.timer_sample (timer_sample),
		.random_word  (random_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_full     (out_full)
	);

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the entropy pool conditioner: directed table, then random traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {
		OP_HARVEST = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef struct {
		op_t         op;
		logic [63:0] sample;
		bit          pinned;
		logic [63:0] word;
	} plan_row_t;

	localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
	localparam int ITEM_TARGET = 1850;
	localparam int QUIET_ITEMS = 200;
	localparam int HOLD_AT     = 3000;
	localparam int HOLD_LEN    = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	function automatic logic [63:0] derive_work_word();
		logic [63:0] w;
		w = 64'h0000_0000_CAFE_BABE;
		for (int r = 0; r < 20; r++) begin
			w = w * 64'd6364136223846793005 + 64'd1442695040888963407;
			w = w ^ (w >> 17);
		end
		return w;
	endfunction

	localparam logic [63:0] WORK_WORD = derive_work_word();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = OP_HARVEST;
	logic [63:0] timer_sample = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] random_word;

	logic        pin_valid = 1'b0;
	logic [63:0] pin_word = '0;
	logic        quiet_tail = 1'b0;
	bit          gaps_on = 1'b1;

	logic [63:0] pool_st [4] = '{default: '0};
	logic [63:0] feeds_st = '0;
	logic [63:0] word_due_q [$];

	int sent = 0;
	int harvests_seen = 0;
	int extracts_seen = 0;
	int words_checked = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	plan_row_t plan [22] = '{
		'{OP_EXTRACT, 64'h0,                   1'b1, 64'h0},
		'{OP_EXTRACT, 64'h0,                   1'b1, 64'h0},
		'{OP_HARVEST, 64'h0,                   1'b0, 64'h0},
		'{OP_HARVEST, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{OP_HARVEST, 64'h1,                   1'b0, 64'h0},
		'{OP_HARVEST, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_EXTRACT, 64'h0,                   1'b0, 64'h0},
		'{OP_HARVEST, WORK_WORD,               1'b0, 64'h0},
		'{OP_HARVEST, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
		'{OP_HARVEST, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
		'{OP_HARVEST, 64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0},
		'{OP_EXTRACT, 64'h0,                   1'b0, 64'h0},
		'{OP_EXTRACT, 64'h0,                   1'b0, 64'h0},
		'{OP_HARVEST, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0},
		'{OP_EXTRACT, 64'h0,                   1'b0, 64'h0},
		'{OP_HARVEST, ~WORK_WORD,              1'b0, 64'h0},
		'{OP_HARVEST, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
		'{OP_HARVEST, 64'hFEDC_BA98_7654_3210, 1'b0, 64'h0},
		'{OP_HARVEST, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{OP_EXTRACT, 64'h0,                   1'b0, 64'h0},
		'{OP_EXTRACT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{OP_EXTRACT, 64'h5555_5555_5555_5555, 1'b0, 64'h0}
	};

	entropy_pool_conditioner_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.timer_sample (timer_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.random_word  (random_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] rol64(input logic [63:0] v, input int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

	function automatic void absorb_sample(input logic [63:0] sample);
		logic [63:0] z;
		logic [1:0]  lane;
		logic [1:0]  next_lane;
		feeds_st = feeds_st + 64'd1;
		z = sample + feeds_st * GOLDEN_STEP;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		z = z ^ (z >> 31);
		lane = feeds_st[1:0];
		next_lane = lane + 2'd1;
		pool_st[lane] = pool_st[lane] ^ z;
		pool_st[next_lane] = pool_st[next_lane] ^ rol64(pool_st[lane], 17);
	endfunction

	function automatic logic [63:0] fold_pool();
		logic [63:0] w;
		w = pool_st[0] ^ rol64(pool_st[1], 13) ^ rol64(pool_st[2], 29) ^ rol64(pool_st[3], 43);
		pool_st[0] = pool_st[0] ^ rol64(w, 7);
		pool_st[1] = pool_st[1] ^ rol64(w, 23);
		return w;
	endfunction

	function automatic logic [63:0] pick_sample();
		logic [63:0] one_hot;
		one_hot = 64'd1 << $urandom_range(0, 63);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return WORK_WORD;
			3: return one_hot;
			4: return ~one_hot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_item(input op_t op, input logic [63:0] sample, input bit pinned,
			input logic [63:0] pinned_word);
		in_valid <= 1'b1;
		opcode <= op;
		timer_sample <= sample;
		pin_valid <= pinned;
		pin_word <= pinned_word;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		logic [63:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (word_due_q.size() == 0) begin
					report_mismatch("unexpected random_word", random_word, '0);
				end else begin
					want = word_due_q.pop_front();
					words_checked++;
					if (random_word !== want) begin
						report_mismatch("random_word", random_word, want);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (opcode == OP_EXTRACT) begin
					want = fold_pool();
					if (pin_valid) begin
						want = pin_word;
					end
					word_due_q.push_back(want);
					extracts_seen++;
				end else begin
					absorb_sample(timer_sample);
					absorb_sample(timer_sample ^ WORK_WORD);
					harvests_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : receiver
		int stall_left;
		int hold_left;
		int ticks;
		stall_left = 0;
		hold_left = 0;
		ticks = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			ticks++;
			if (ticks == HOLD_AT) begin
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (quiet_tail) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		bit paused;
		int n;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_item(plan[i].op, plan[i].sample, plan[i].pinned, plan[i].word);
		end

		while (sent < ITEM_TARGET) begin
			if (!paused && sent >= ITEM_TARGET / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait (word_due_q.size() == 0);
				@(posedge clk);
				paused = 1'b1;
			end
			if (sent >= ITEM_TARGET - QUIET_ITEMS) begin
				quiet_tail <= 1'b1;
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0) begin
				repeat (4) send_item(OP_HARVEST, pick_sample(), 1'b0, '0);
				send_item(OP_EXTRACT, pick_sample(), 1'b0, '0);
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_item(op_t'($urandom_range(0, 1)), pick_sample(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (word_due_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items (%0d harvests, %0d extracts): directed rows, then random",
			sent, harvests_seen, extracts_seen);
		$display("blocks with stalls on both sides; %0d words checked, %0d mismatches.",
			words_checked, mismatches);
		if (mismatches == 0 && word_due_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

[filelist.f]
hw/rtl/epc_pkg.sv
hw/rtl/epc_sequencer.sv
hw/rtl/epc_datapath.sv
hw/rtl/entropy_pool_conditioner_core.sv
bench/tb.sv
